/* sv/ndrm_pkg.sv */
// Package for the descriptor ring manager: shared types, codes and constants.
// No dependencies; compiled first.
package ndrm_pkg;

   // Field widths of the channels
   localparam int OPCODE_W = 3;
   localparam int FLEN_W   = 14;
   localparam int LIMIT_W  = 16;
   localparam int STATUS_W = 17;
   localparam int CODE_W   = 3;
   localparam int SLOT_W   = 4;
   localparam int TXLEN_W  = 11;
   localparam int EVENT_W  = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 17;

   // Length constants
   localparam logic [FLEN_W-1:0] FL_MAX    = 14'h3FFF;
   localparam logic [FLEN_W-1:0] FCS_BYTES = 14'd4;

   // Status word bit positions
   localparam int ST_TI_BIT  = 0;
   localparam int ST_TU_BIT  = 2;
   localparam int ST_RI_BIT  = 6;
   localparam int ST_RU_BIT  = 7;
   localparam int ST_AIS_BIT = 15;
   localparam int ST_NIS_BIT = 16;

   // Event register bit positions
   localparam int EV_TI = 0;
   localparam int EV_TU = 1;
   localparam int EV_RI = 2;
   localparam int EV_RU = 3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IRQ_MASK  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TX_ENABLE = 2'd2;

   // Request opcodes
   typedef enum logic [OPCODE_W-1:0] {
      OP_TX_SUBMIT     = 3'd0,
      OP_RX_TAKE       = 3'd1,
      OP_FRAME_ARRIVED = 3'd2,
      OP_FRAME_SENT    = 3'd3,
      OP_STATUS_READ   = 3'd4,
      OP_STATUS_CLEAR  = 3'd5,
      OP_SOFT_RESET    = 3'd6
   } op_type;

   // Result codes
   typedef enum logic [CODE_W-1:0] {
      RC_OK         = 3'd0,
      RC_EMPTY_BUSY = 3'd1,
      RC_TOO_LONG   = 3'd2,
      RC_BAD_LEN    = 3'd3,
      RC_DROPPED    = 3'd4
   } rc_type;

   // Decoded command passed from the front end to the back end
   typedef struct packed {
      op_type               op;
      logic                 too_long;
      logic [TXLEN_W-1:0]   tx_len;
      logic [FLEN_W-1:0]    fill_len;
      logic [LIMIT_W-1:0]   byte_limit;
      logic [EVENT_W-1:0]   clear_events;
   } cmd_type;

   // Back end sequencer states
   typedef enum logic {
      BK_IDLE,
      BK_EXEC
   } bk_state_type;

endpackage

/* sv/ndrm_if.sv */
// Channel interfaces of the descriptor ring manager: request, response, CSR write.
// Depends on ndrm_pkg.
interface ndrm_req_if;
   logic                            valid;
   logic                            ready;
   logic [ndrm_pkg::OPCODE_W-1:0]   opcode;
   logic [ndrm_pkg::FLEN_W-1:0]     frame_length;
   logic [ndrm_pkg::LIMIT_W-1:0]    byte_limit;
   logic [ndrm_pkg::STATUS_W-1:0]   clear_bits;
   modport source (output valid, opcode, frame_length, byte_limit, clear_bits, input ready);
   modport sink   (input valid, opcode, frame_length, byte_limit, clear_bits, output ready);
endinterface

interface ndrm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ndrm_pkg::CODE_W-1:0]     result_code;
   logic [ndrm_pkg::FLEN_W-1:0]     byte_count;
   logic [ndrm_pkg::SLOT_W-1:0]     slot_index;
   logic [ndrm_pkg::STATUS_W-1:0]   status_word;
   logic                            irq;
   modport source (output valid, result_code, byte_count, slot_index, status_word, irq,
                   input ready);
   modport sink   (input valid, result_code, byte_count, slot_index, status_word, irq,
                   output ready);
endinterface

interface ndrm_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ndrm_pkg::CSR_IDX_W-1:0]   index;
   logic [ndrm_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* sv/ndrm_front.sv */
// Front end: accepts request beats, decodes the opcode and pre-checks lengths.
// Depends on ndrm_pkg and ndrm_if.
module ndrm_front #(
   parameter int TX_BUFFER_BYTES = 2048
) (
   ndrm_req_if.sink            req_bus,
   output logic                push_valid,
   input  logic                push_ready,
   output ndrm_pkg::cmd_type   push_cmd
);
   import ndrm_pkg::*;

   logic [FLEN_W:0] fill_sum;

   // Handshake passes straight to the queue
   assign push_valid    = req_bus.valid;
   assign req_bus.ready = push_ready;

   // Stored receive length: frame plus FCS, saturated
   assign fill_sum = {1'b0, req_bus.frame_length} + {1'b0, FCS_BYTES};

   // Decode: unused opcode acts as a status read
   always_comb begin
      case (req_bus.opcode)
         OP_TX_SUBMIT:     push_cmd.op = OP_TX_SUBMIT;
         OP_RX_TAKE:       push_cmd.op = OP_RX_TAKE;
         OP_FRAME_ARRIVED: push_cmd.op = OP_FRAME_ARRIVED;
         OP_FRAME_SENT:    push_cmd.op = OP_FRAME_SENT;
         OP_STATUS_CLEAR:  push_cmd.op = OP_STATUS_CLEAR;
         OP_SOFT_RESET:    push_cmd.op = OP_SOFT_RESET;
         default:          push_cmd.op = OP_STATUS_READ;
      endcase
      push_cmd.too_long = (req_bus.frame_length >= FLEN_W'(TX_BUFFER_BYTES));
      push_cmd.tx_len   = req_bus.frame_length[TXLEN_W-1:0];
      push_cmd.fill_len = fill_sum[FLEN_W] ? FL_MAX : fill_sum[FLEN_W-1:0];
      push_cmd.byte_limit = req_bus.byte_limit;
      push_cmd.clear_events[EV_TI] = req_bus.clear_bits[ST_TI_BIT];
      push_cmd.clear_events[EV_TU] = req_bus.clear_bits[ST_TU_BIT];
      push_cmd.clear_events[EV_RI] = req_bus.clear_bits[ST_RI_BIT];
      push_cmd.clear_events[EV_RU] = req_bus.clear_bits[ST_RU_BIT];
   end

endmodule

/* sv/ndrm_cmd_queue.sv */
// Two-entry command queue between the front end and the back end.
// Depends on ndrm_pkg.
module ndrm_cmd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  ndrm_pkg::cmd_type   push_cmd,
   output logic                pop_valid,
   input  logic                pop_ready,
   output ndrm_pkg::cmd_type   pop_cmd
);
   import ndrm_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* sv/ndrm_back.sv */
// Back end: ring ownership, length memories, pointers, status and CSRs.
// Executes one queued command at a time into a registered response.
// Depends on ndrm_pkg and ndrm_if.
module ndrm_back #(
   parameter int RX_DEPTH        = 16,
   parameter int TX_DEPTH        = 8,
   parameter int RX_BUFFER_BYTES = 2047
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  ndrm_pkg::cmd_type   pop_cmd,
   ndrm_rsp_if.source          rsp_bus,
   ndrm_csr_if.sink            csr_bus
);
   import ndrm_pkg::*;

   localparam int RX_PW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int TX_PW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam logic [FLEN_W-1:0] RX_LEN_MAX = FLEN_W'(RX_BUFFER_BYTES + 4);

   // Sequencer
   bk_state_type state_ff, state_in;
   cmd_type      cmd_ff;
   logic         commit;
   logic         out_free;

   // Ring state
   logic [RX_DEPTH-1:0] rx_own_ff, rx_own_in;
   logic [TX_DEPTH-1:0] tx_own_ff, tx_own_in;
   logic [RX_PW-1:0]    rx_fill_ff, rx_fill_in;
   logic [RX_PW-1:0]    rx_take_ff, rx_take_in;
   logic [TX_PW-1:0]    tx_sub_ff, tx_sub_in;
   logic [TX_PW-1:0]    tx_send_ff, tx_send_in;
   logic [EVENT_W-1:0]  events_ff, events_in;

   // Length memories and registered read data
   logic [FLEN_W-1:0]   rx_len_mem [RX_DEPTH];
   logic [TXLEN_W-1:0]  tx_len_mem [TX_DEPTH];
   logic [FLEN_W-1:0]   rx_rd_ff;
   logic [TXLEN_W-1:0]  tx_rd_ff;
   logic                rx_wr_en, tx_wr_en;

   // Configuration registers
   logic [STATUS_W-1:0] irq_mask_ff, irq_mask_in;
   logic                rx_enable_ff, rx_enable_in;
   logic                tx_enable_ff, tx_enable_in;

   // Response register
   logic                rsp_valid_ff;
   logic [CODE_W-1:0]   code_ff;
   logic [FLEN_W-1:0]   count_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                irq_ff;
   rc_type              code_in;
   logic [FLEN_W-1:0]   count_in;
   logic [SLOT_W-1:0]   slot_in;
   logic [STATUS_W-1:0] status_in;
   logic                irq_in;

   logic [FLEN_W-1:0]   rx_payload;
   logic [LIMIT_W-1:0]  rx_payload_wide;
   logic                nis, ais;

   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign commit    = (state_ff == BK_EXEC) && out_free;
   // CSR beat is held off in a commit cycle, which owns the CSR registers
   assign csr_bus.ready = !commit;

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.result_code = code_ff;
   assign rsp_bus.byte_count  = count_ff;
   assign rsp_bus.slot_index  = slot_ff;
   assign rsp_bus.status_word = status_ff;
   assign rsp_bus.irq         = irq_ff;

   // Sequencer: fetch reads the memories, exec commits
   always_comb begin
      state_in  = state_ff;
      pop_ready = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Latch command and read ring lengths at the current pointers
   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         cmd_ff   <= pop_cmd;
         rx_rd_ff <= rx_len_mem[rx_take_ff];
         tx_rd_ff <= tx_len_mem[tx_send_ff];
      end
   end

   // Memory writes at commit
   always_ff @(posedge clock) begin
      if (rx_wr_en) begin
         rx_len_mem[rx_fill_ff] <= cmd_ff.fill_len;
      end
      if (tx_wr_en) begin
         tx_len_mem[tx_sub_ff] <= cmd_ff.tx_len;
      end
   end

   // Receive take byte count: length less FCS, capped by the caller limit
   assign rx_payload      = rx_rd_ff - FCS_BYTES;
   assign rx_payload_wide = LIMIT_W'(rx_payload);

   // Command execution
   always_comb begin
      rx_own_in    = rx_own_ff;
      tx_own_in    = tx_own_ff;
      rx_fill_in   = rx_fill_ff;
      rx_take_in   = rx_take_ff;
      tx_sub_in    = tx_sub_ff;
      tx_send_in   = tx_send_ff;
      events_in    = events_ff;
      irq_mask_in  = irq_mask_ff;
      rx_enable_in = rx_enable_ff;
      tx_enable_in = tx_enable_ff;
      rx_wr_en     = 1'b0;
      tx_wr_en     = 1'b0;
      code_in      = RC_OK;
      count_in     = '0;
      slot_in      = '0;

      case (cmd_ff.op)
         OP_TX_SUBMIT: begin
            slot_in = SLOT_W'(tx_sub_ff);
            if (cmd_ff.too_long) begin
               code_in = RC_TOO_LONG;
            end else if (tx_own_ff[tx_sub_ff]) begin
               code_in = RC_EMPTY_BUSY;
            end else begin
               tx_wr_en = commit;
               tx_own_in[tx_sub_ff] = 1'b1;
               tx_sub_in = (tx_sub_ff == TX_PW'(TX_DEPTH - 1)) ? '0
                                                                : tx_sub_ff + TX_PW'(1);
            end
         end
         OP_RX_TAKE: begin
            slot_in = SLOT_W'(rx_take_ff);
            if (rx_own_ff[rx_take_ff]) begin
               code_in = RC_EMPTY_BUSY;
            end else begin
               if (rx_rd_ff < FCS_BYTES || rx_rd_ff > RX_LEN_MAX) begin
                  code_in = RC_BAD_LEN;
               end else if (cmd_ff.byte_limit < rx_payload_wide) begin
                  count_in = cmd_ff.byte_limit[FLEN_W-1:0];
               end else begin
                  count_in = rx_payload;
               end
               rx_own_in[rx_take_ff] = 1'b1;
               rx_take_in = (rx_take_ff == RX_PW'(RX_DEPTH - 1)) ? '0
                                                                 : rx_take_ff + RX_PW'(1);
            end
         end
         OP_FRAME_ARRIVED: begin
            slot_in = SLOT_W'(rx_fill_ff);
            if (!rx_enable_ff) begin
               code_in = RC_DROPPED;
            end else if (!rx_own_ff[rx_fill_ff]) begin
               events_in[EV_RU] = 1'b1;
               code_in = RC_DROPPED;
            end else begin
               rx_wr_en = commit;
               rx_own_in[rx_fill_ff] = 1'b0;
               rx_fill_in = (rx_fill_ff == RX_PW'(RX_DEPTH - 1)) ? '0
                                                                 : rx_fill_ff + RX_PW'(1);
               events_in[EV_RI] = 1'b1;
            end
         end
         OP_FRAME_SENT: begin
            slot_in = SLOT_W'(tx_send_ff);
            if (!tx_enable_ff) begin
               code_in = RC_DROPPED;
            end else if (!tx_own_ff[tx_send_ff]) begin
               events_in[EV_TU] = 1'b1;
               code_in = RC_DROPPED;
            end else begin
               count_in = FLEN_W'(tx_rd_ff);
               tx_own_in[tx_send_ff] = 1'b0;
               tx_send_in = (tx_send_ff == TX_PW'(TX_DEPTH - 1)) ? '0
                                                                 : tx_send_ff + TX_PW'(1);
               events_in[EV_TI] = 1'b1;
            end
         end
         OP_STATUS_CLEAR: begin
            events_in = events_ff & ~cmd_ff.clear_events;
         end
         OP_SOFT_RESET: begin
            rx_own_in    = '1;
            tx_own_in    = '0;
            rx_fill_in   = '0;
            rx_take_in   = '0;
            tx_sub_in    = '0;
            tx_send_in   = '0;
            events_in    = '0;
            irq_mask_in  = '0;
            rx_enable_in = 1'b0;
            tx_enable_in = 1'b0;
         end
         default: begin
         end
      endcase

      // Status word and interrupt after the operation
      status_in = '0;
      status_in[ST_TI_BIT] = events_in[EV_TI];
      status_in[ST_TU_BIT] = events_in[EV_TU];
      status_in[ST_RI_BIT] = events_in[EV_RI];
      status_in[ST_RU_BIT] = events_in[EV_RU];
      nis = (events_in[EV_TI] && irq_mask_in[ST_TI_BIT])
         || (events_in[EV_TU] && irq_mask_in[ST_TU_BIT])
         || (events_in[EV_RI] && irq_mask_in[ST_RI_BIT]);
      ais = events_in[EV_RU] && irq_mask_in[ST_RU_BIT];
      status_in[ST_NIS_BIT] = nis;
      status_in[ST_AIS_BIT] = ais;
      irq_in = (nis && irq_mask_in[ST_NIS_BIT]) || (ais && irq_mask_in[ST_AIS_BIT]);
   end

   // Ring state, events and CSRs
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_own_ff    <= '1;
         tx_own_ff    <= '0;
         rx_fill_ff   <= '0;
         rx_take_ff   <= '0;
         tx_sub_ff    <= '0;
         tx_send_ff   <= '0;
         events_ff    <= '0;
         irq_mask_ff  <= '0;
         rx_enable_ff <= 1'b0;
         tx_enable_ff <= 1'b0;
      end else if (commit) begin
         rx_own_ff    <= rx_own_in;
         tx_own_ff    <= tx_own_in;
         rx_fill_ff   <= rx_fill_in;
         rx_take_ff   <= rx_take_in;
         tx_sub_ff    <= tx_sub_in;
         tx_send_ff   <= tx_send_in;
         events_ff    <= events_in;
         irq_mask_ff  <= irq_mask_in;
         rx_enable_ff <= rx_enable_in;
         tx_enable_ff <= tx_enable_in;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_IRQ_MASK:  irq_mask_ff  <= csr_bus.data[STATUS_W-1:0];
            CSR_RX_ENABLE: rx_enable_ff <= csr_bus.data[0];
            CSR_TX_ENABLE: tx_enable_ff <= csr_bus.data[0];
            default: begin
            end
         endcase
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         code_ff   <= code_in;
         count_ff  <= count_in;
         slot_ff   <= slot_in;
         status_ff <= status_in;
         irq_ff    <= irq_in;
      end
   end

endmodule

/* sv/nic_descriptor_ring_manager.sv */
// Descriptor ring manager for a network controller: receive and transmit
// ownership rings, interrupt status and mask.
// Channels: req_bus carries one operation per beat (tx submit, rx take,
// frame arrived, frame sent, status read, status clear, soft reset);
// rsp_bus returns exactly one result beat per request, in order; csr_bus
// writes irq_mask (index 0), rx_enable (1) and tx_enable (2). The user is to make
// CSR writes only while no request is outstanding; the block does not enforce
// this. csr_bus is ready except in a cycle where the back end commits a command.
// Each accepted request beat passes the queue write, the length-memory read and
// the execute step into the response register before its result beat is shown.
// The back end takes no new request until the current one has executed, since
// the ring length memories are read into a register before each execute step.
// When rsp_bus stalls the result is held, the two-entry queue fills and
// req_bus.ready drops.
// Reset (synchronous): receive entries owned by the chip, transmit entries
// owned by the host, pointers, events and CSRs cleared; length memories are
// not cleared since they are only read after being written. The soft reset
// operation does the same.
// Depends on ndrm_pkg, ndrm_if, ndrm_front, ndrm_cmd_queue, ndrm_back.
module nic_descriptor_ring_manager #(
   parameter int RX_DEPTH        = 16,
   parameter int TX_DEPTH        = 8,
   parameter int RX_BUFFER_BYTES = 2047,
   parameter int TX_BUFFER_BYTES = 2048
) (
   input  logic        clock,
   input  logic        reset,
   ndrm_req_if.sink    req_bus,
   ndrm_rsp_if.source  rsp_bus,
   ndrm_csr_if.sink    csr_bus
);
   import ndrm_pkg::*;

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   // Decode
   ndrm_front #(
      .TX_BUFFER_BYTES (TX_BUFFER_BYTES)
   ) u_front (
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // Decoupling queue
   ndrm_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // Execute
   ndrm_back #(
      .RX_DEPTH        (RX_DEPTH),
      .TX_DEPTH        (TX_DEPTH),
      .RX_BUFFER_BYTES (RX_BUFFER_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_bus   (rsp_bus),
      .csr_bus   (csr_bus)
   );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Testbench for nic_descriptor_ring_manager: ring ownership, length checks and status/irq.
// Uses ndrm_pkg and the ndrm_req_if / ndrm_rsp_if / ndrm_csr_if channels of the RTL.
module tb;
   import ndrm_pkg::*;

   localparam int RX_DEPTH        = 16;
   localparam int TX_DEPTH        = 8;
   localparam int RX_BUFFER_BYTES = 2047;
   localparam int TX_BUFFER_BYTES = 2048;
   localparam int SETTLE_CYCLES   = 6;       // pipeline is three deep; allow margin
   localparam int LONG_HOLD       = 150;
   localparam int CYCLE_LIMIT     = 300000;

   // opcode 7 is not decoded and behaves as a status read
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

   localparam logic [STATUS_W-1:0] BIT_TI  = STATUS_W'(1) << ST_TI_BIT;
   localparam logic [STATUS_W-1:0] BIT_TU  = STATUS_W'(1) << ST_TU_BIT;
   localparam logic [STATUS_W-1:0] BIT_RI  = STATUS_W'(1) << ST_RI_BIT;
   localparam logic [STATUS_W-1:0] BIT_RU  = STATUS_W'(1) << ST_RU_BIT;
   localparam logic [STATUS_W-1:0] BIT_AIS = STATUS_W'(1) << ST_AIS_BIT;
   localparam logic [STATUS_W-1:0] BIT_NIS = STATUS_W'(1) << ST_NIS_BIT;
   localparam logic [STATUS_W-1:0] MASK_USED =
      BIT_TI | BIT_TU | BIT_RI | BIT_RU | BIT_AIS | BIT_NIS;
   localparam logic [STATUS_W-1:0] ALL_ONES = '1;

   typedef struct {
      logic [OPCODE_W-1:0] opcode;
      logic [FLEN_W-1:0]   flen;
      logic [LIMIT_W-1:0]  limit;
      logic [STATUS_W-1:0] clr;
   } ring_op_type;

   typedef struct {
      rc_type              code;
      logic [FLEN_W-1:0]   count;
      logic [SLOT_W-1:0]   slot;
      logic [STATUS_W-1:0] status;
      logic                irq;
   } ring_result_type;

   logic clock = 1'b0;
   logic reset;

   ndrm_req_if req_bus ();
   ndrm_rsp_if rsp_bus ();
   ndrm_csr_if csr_bus ();

   nic_descriptor_ring_manager u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   // Shadow copy of the rings, pointers, events and registers
   logic                rx_chip_own [RX_DEPTH];
   logic [FLEN_W-1:0]   rx_len      [RX_DEPTH];
   logic                tx_chip_own [TX_DEPTH];
   logic [TXLEN_W-1:0]  tx_len      [TX_DEPTH];
   logic [3:0]          rx_fill_ptr, rx_take_ptr;
   logic [2:0]          tx_sub_ptr, tx_send_ptr;
   logic [EVENT_W-1:0]  events;
   logic [STATUS_W-1:0] mask_reg;
   logic                rx_on, tx_on;

   ring_result_type results_due [$];
   bit           failed = 1'b0;
   bit           quiet  = 1'b0;
   int           holds_asked = 0;
   int           holds_served = 0;
   int           rsp_hold = 0;
   int           cycles_run = 0;

   function automatic void reset_rings();
      for (int i = 0; i < RX_DEPTH; i++) begin
         rx_chip_own[i] = 1'b1;
         rx_len[i]      = '0;
      end
      for (int i = 0; i < TX_DEPTH; i++) begin
         tx_chip_own[i] = 1'b0;
         tx_len[i]      = '0;
      end
      rx_fill_ptr = '0;
      rx_take_ptr = '0;
      tx_sub_ptr  = '0;
      tx_send_ptr = '0;
      events      = '0;
      mask_reg    = '0;
      rx_on       = 1'b0;
      tx_on       = 1'b0;
   endfunction

   // Event bits mapped into status positions plus the masked summaries
   function automatic logic [STATUS_W-1:0] status_view();
      logic [STATUS_W-1:0] s;
      logic [STATUS_W-1:0] m;
      s = '0;
      s[ST_TI_BIT] = events[EV_TI];
      s[ST_TU_BIT] = events[EV_TU];
      s[ST_RI_BIT] = events[EV_RI];
      s[ST_RU_BIT] = events[EV_RU];
      m = mask_reg & MASK_USED;
      if (|(s & m & (BIT_TI | BIT_TU | BIT_RI))) s[ST_NIS_BIT] = 1'b1;
      if (|(s & m & BIT_RU)) s[ST_AIS_BIT] = 1'b1;
      return s;
   endfunction

   // Apply one accepted operation to the shadow state and build its result
   function automatic ring_result_type advance_rings(ring_op_type it);
      ring_result_type r;
      int           len;
      int           cnt;
      r.code  = RC_OK;
      r.count = '0;
      r.slot  = '0;
      case (it.opcode)
         OP_TX_SUBMIT: begin
            r.slot = SLOT_W'(tx_sub_ptr);
            if (it.flen >= TX_BUFFER_BYTES) begin
               r.code = RC_TOO_LONG;
            end else if (tx_chip_own[tx_sub_ptr]) begin
               r.code = RC_EMPTY_BUSY;
            end else begin
               tx_len[tx_sub_ptr]      = it.flen[TXLEN_W-1:0];
               tx_chip_own[tx_sub_ptr] = 1'b1;
               tx_sub_ptr              = tx_sub_ptr + 3'd1;   // wraps at TX_DEPTH
            end
         end
         OP_RX_TAKE: begin
            r.slot = SLOT_W'(rx_take_ptr);
            if (rx_chip_own[rx_take_ptr]) begin
               r.code = RC_EMPTY_BUSY;
            end else begin
               len = int'(rx_len[rx_take_ptr]);
               if (len < FCS_BYTES || len > RX_BUFFER_BYTES + FCS_BYTES) begin
                  r.code = RC_BAD_LEN;          // resync: entry still handed back
               end else begin
                  cnt = len - FCS_BYTES;
                  if (int'(it.limit) < cnt) cnt = int'(it.limit);
                  r.count = FLEN_W'(cnt);
               end
               rx_chip_own[rx_take_ptr] = 1'b1;
               rx_take_ptr              = rx_take_ptr + 4'd1;
            end
         end
         OP_FRAME_ARRIVED: begin
            r.slot = SLOT_W'(rx_fill_ptr);
            if (!rx_on) begin
               r.code = RC_DROPPED;
            end else if (!rx_chip_own[rx_fill_ptr]) begin
               events[EV_RU] = 1'b1;
               r.code        = RC_DROPPED;
            end else begin
               len = int'(it.flen) + FCS_BYTES;
               if (len > FL_MAX) len = FL_MAX;    // saturate stored length
               rx_len[rx_fill_ptr]      = FLEN_W'(len);
               rx_chip_own[rx_fill_ptr] = 1'b0;
               rx_fill_ptr              = rx_fill_ptr + 4'd1;
               events[EV_RI]            = 1'b1;
            end
         end
         OP_FRAME_SENT: begin
            r.slot = SLOT_W'(tx_send_ptr);
            if (!tx_on) begin
               r.code = RC_DROPPED;
            end else if (!tx_chip_own[tx_send_ptr]) begin
               events[EV_TU] = 1'b1;
               r.code        = RC_DROPPED;
            end else begin
               r.count                  = FLEN_W'(tx_len[tx_send_ptr]);
               tx_chip_own[tx_send_ptr] = 1'b0;
               tx_send_ptr              = tx_send_ptr + 3'd1;
               events[EV_TI]            = 1'b1;
            end
         end
         OP_STATUS_CLEAR: begin
            if (it.clr[ST_TI_BIT]) events[EV_TI] = 1'b0;
            if (it.clr[ST_TU_BIT]) events[EV_TU] = 1'b0;
            if (it.clr[ST_RI_BIT]) events[EV_RI] = 1'b0;
            if (it.clr[ST_RU_BIT]) events[EV_RU] = 1'b0;
         end
         OP_SOFT_RESET: reset_rings();
         default: ;                             // status read and the unused code
      endcase
      r.status = status_view();
      r.irq    = |(r.status & mask_reg & MASK_USED & (BIT_NIS | BIT_AIS));
      return r;
   endfunction

   // Request side: optional idle burst, then one beat
   task automatic send_item(input ring_op_type it);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= it.opcode;
      req_bus.frame_length <= it.flen;
      req_bus.byte_limit   <= it.limit;
      req_bus.clear_bits   <= it.clr;
      do @(posedge clock); while (!req_bus.ready);
      results_due.push_back(advance_rings(it));
   endtask

   task automatic send_op(input logic [OPCODE_W-1:0] op, input int flen, input int limit,
                          input logic [STATUS_W-1:0] clr);
      ring_op_type it;
      it.opcode = op;
      it.flen   = FLEN_W'(flen);
      it.limit  = LIMIT_W'(limit);
      it.clr    = clr;
      send_item(it);
   endtask

   // Stop offering, wait for every outstanding result, let the pipeline go quiet
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_beat(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_IRQ_MASK:  mask_reg = val;
         CSR_RX_ENABLE: rx_on    = val[0];
         CSR_TX_ENABLE: tx_on    = val[0];
         default: ;
      endcase
   endtask

   // Writes all three registers back to back; only called while idle
   task automatic set_config(input logic [CSR_DATA_W-1:0] mask, input logic [CSR_DATA_W-1:0] rxv,
                             input logic [CSR_DATA_W-1:0] txv);
      csr_beat(CSR_IRQ_MASK, mask);
      csr_beat(CSR_RX_ENABLE, rxv);
      csr_beat(CSR_TX_ENABLE, txv);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic ring_op_type random_item();
      ring_op_type it;
      int       pick;
      pick = $urandom_range(0, 99);
      if (pick < 21)      it.opcode = OP_TX_SUBMIT;
      else if (pick < 42) it.opcode = OP_RX_TAKE;
      else if (pick < 63) it.opcode = OP_FRAME_ARRIVED;
      else if (pick < 83) it.opcode = OP_FRAME_SENT;
      else if (pick < 88) it.opcode = OP_STATUS_READ;
      else if (pick < 96) it.opcode = OP_STATUS_CLEAR;
      else if (pick < 99) it.opcode = OP_UNUSED;
      else                it.opcode = OP_SOFT_RESET;
      // mostly lengths that fit, sometimes anything up to the field maximum
      it.flen  = ($urandom_range(0, 6) == 0) ? FLEN_W'($urandom_range(0, 16383))
                                              : FLEN_W'($urandom_range(0, TX_BUFFER_BYTES - 1));
      it.limit = $urandom_range(0, 1) ? LIMIT_W'($urandom_range(0, 65535))
                                      : LIMIT_W'($urandom_range(0, 2100));
      it.clr   = STATUS_W'($urandom_range(0, 131071));
      return it;
   endfunction

   // ---------------- directed tests ----------------

   // Registers still at reset: both processes stopped, rings idle
   task automatic test_stopped_rings();
      send_op(OP_STATUS_READ, 0, 0, '0);
      send_op(OP_UNUSED, 16383, 65535, ALL_ONES);
      send_op(OP_RX_TAKE, 0, 65535, '0);
      send_op(OP_FRAME_SENT, 0, 0, '0);
      send_op(OP_FRAME_ARRIVED, 100, 0, '0);
      send_op(OP_STATUS_CLEAR, 0, 0, ALL_ONES);
   endtask

   // Too-long checks at the buffer edge, length extremes, underrun on empty ring
   task automatic test_tx_ring();
      drain_results();
      set_config(ALL_ONES, 1, 1);
      send_op(OP_TX_SUBMIT, TX_BUFFER_BYTES, 0, '0);
      send_op(OP_TX_SUBMIT, 16383, 0, '0);
      send_op(OP_TX_SUBMIT, 0, 0, '0);
      send_op(OP_TX_SUBMIT, TX_BUFFER_BYTES - 1, 0, '0);
      send_op(OP_FRAME_SENT, 0, 0, '0);
      send_op(OP_FRAME_SENT, 0, 0, '0);
      send_op(OP_FRAME_SENT, 0, 0, '0);
   endtask

   // Good, saturated and bad stored lengths; byte limit at both ends; empty ring
   task automatic test_rx_ring();
      send_op(OP_FRAME_ARRIVED, 0, 0, '0);
      send_op(OP_FRAME_ARRIVED, 16383, 0, '0);
      send_op(OP_FRAME_ARRIVED, RX_BUFFER_BYTES, 0, '0);
      send_op(OP_FRAME_ARRIVED, RX_BUFFER_BYTES + 1, 0, '0);
      send_op(OP_FRAME_ARRIVED, 100, 0, '0);
      send_op(OP_RX_TAKE, 0, 65535, '0);
      send_op(OP_RX_TAKE, 0, 65535, '0);
      send_op(OP_RX_TAKE, 0, 65535, '0);
      send_op(OP_RX_TAKE, 0, 65535, '0);
      send_op(OP_RX_TAKE, 0, 0, '0);
      send_op(OP_RX_TAKE, 0, 65535, '0);
   endtask

   // Partial and full write-one-to-clear, then soft reset drops the registers too
   task automatic test_clear_and_soft_reset();
      send_op(OP_STATUS_CLEAR, 0, 0, BIT_TI);
      send_op(OP_STATUS_CLEAR, 0, 0, ALL_ONES);
      send_op(OP_TX_SUBMIT, 64, 0, '0);
      send_op(OP_SOFT_RESET, 16383, 65535, ALL_ONES);
      send_op(OP_FRAME_ARRIVED, 64, 0, '0);
   endtask

   // ---------------- random tests ----------------

   task automatic test_random_mix(input int count, input logic [CSR_DATA_W-1:0] mask,
                                  input logic [CSR_DATA_W-1:0] rxv,
                                  input logic [CSR_DATA_W-1:0] txv);
      ring_op_type it;
      drain_results();
      set_config(mask, rxv, txv);
      repeat (count) begin
         it = random_item();
         send_item(it);
         // soft reset clears the registers; restore this phase's setting
         if (it.opcode == OP_SOFT_RESET) begin
            drain_results();
            set_config(mask, rxv, txv);
         end
      end
   endtask

   // Run both rings past full and empty so every pointer wraps
   task automatic test_ring_wrap(input int rounds);
      ring_op_type it;
      drain_results();
      set_config(CSR_DATA_W'($urandom_range(0, 131071)), 1, 1);
      repeat (rounds) begin
         repeat (TX_DEPTH + 1) begin
            it = random_item();
            it.opcode = OP_TX_SUBMIT;
            it.flen   = FLEN_W'($urandom_range(0, TX_BUFFER_BYTES - 1));
            send_item(it);
         end
         repeat (RX_DEPTH + 1) begin
            it = random_item();
            it.opcode = OP_FRAME_ARRIVED;
            send_item(it);
         end
         repeat (TX_DEPTH + 1) begin
            it = random_item();
            it.opcode = OP_FRAME_SENT;
            send_item(it);
         end
         repeat (RX_DEPTH + 1) begin
            it = random_item();
            it.opcode = OP_RX_TAKE;
            send_item(it);
         end
         it = random_item();
         it.opcode = OP_STATUS_CLEAR;
         send_item(it);
      end
   endtask

   // Receiver holds off while requests keep coming; then a full pause to drain
   task automatic test_backpressure();
      ring_op_type it;
      drain_results();
      set_config(ALL_ONES, 1, 1);
      holds_asked <= holds_asked + 1;
      repeat (40) begin
         it = random_item();
         if (it.opcode == OP_SOFT_RESET) it.opcode = OP_STATUS_READ;
         send_item(it);
      end
      drain_results();
      repeat (40) begin
         it = random_item();
         if (it.opcode == OP_SOFT_RESET) it.opcode = OP_STATUS_READ;
         send_item(it);
      end
   endtask

   // ---------------- response side ----------------

   // Ready: long holds on request, random stall bursts unless quiet
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold      <= 0;
      end else if (holds_served != holds_asked) begin
         holds_served  <= holds_asked;
         rsp_hold      <= LONG_HOLD - 1;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold      <= rsp_hold - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_hold      <= $urandom_range(1, 18) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   function automatic void compare_field(input string name, input logic [STATUS_W-1:0] want,
                                         input logic [STATUS_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         failed = 1'b1;
      end
   endfunction

   // Each result beat against the oldest expectation
   always @(posedge clock) begin
      ring_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (results_due.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual code %0d slot %0d",
                     $time, rsp_bus.result_code, rsp_bus.slot_index);
            failed = 1'b1;
         end else begin
            want = results_due.pop_front();
            compare_field("result_code", STATUS_W'(want.code),
                          STATUS_W'(rsp_bus.result_code));
            compare_field("byte_count", STATUS_W'(want.count), STATUS_W'(rsp_bus.byte_count));
            compare_field("slot_index", STATUS_W'(want.slot), STATUS_W'(rsp_bus.slot_index));
            compare_field("status_word", want.status, rsp_bus.status_word);
            compare_field("irq", STATUS_W'(want.irq), STATUS_W'(rsp_bus.irq));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
      if (cycles_run > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.opcode       = '0;
      req_bus.frame_length = '0;
      req_bus.byte_limit   = '0;
      req_bus.clear_bits   = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = '0;
      csr_bus.data         = '0;
      reset_rings();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_stopped_rings();
      test_tx_ring();
      test_rx_ring();
      test_clear_and_soft_reset();

      test_random_mix(300, ALL_ONES, 1, 1);
      test_random_mix(150, CSR_DATA_W'($urandom_range(0, 131071)), 1,
                      CSR_DATA_W'({$urandom_range(0, 65535), 1'b0}));
      test_random_mix(120, '0, '0, CSR_DATA_W'({$urandom_range(0, 65535), 1'b1}));
      test_ring_wrap(3);
      test_backpressure();
      test_random_mix(100, CSR_DATA_W'($urandom_range(0, 131071)), 1, 1);

      // closing stretch without idling on either side
      quiet <= 1'b1;
      test_random_mix(200, ALL_ONES, 1, 1);

      drain_results();
      if (!failed) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/ndrm_pkg.sv
sv/ndrm_if.sv
sv/ndrm_front.sv
sv/ndrm_cmd_queue.sv
sv/ndrm_back.sv
sv/nic_descriptor_ring_manager.sv
tb/sv/tb.sv
